@@ src/frt_pkg.sv @@
// shared constants, codes and types of the fragment reassembly tracker
package frt_pkg;

    localparam int NUM_TRANSFER_IDS = 256;
    localparam int MAX_FRAGMENTS    = 64;

    localparam int OP_W    = 2;
    localparam int ID_W    = 8;
    localparam int IDX_W   = 8;
    localparam int TOTAL_W = 8;
    localparam int LEN_W   = 16;
    localparam int STAT_W  = 3;
    localparam int COUNT_W = 7;

    localparam int ADDR_W = (NUM_TRANSFER_IDS > 1) ? $clog2(NUM_TRANSFER_IDS) : 1;
    localparam int BIT_W  = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;

    localparam logic [ID_W:0]    ID_LIMIT    = (ID_W + 1)'(NUM_TRANSFER_IDS);
    localparam logic [IDX_W:0]   IDX_LIMIT   = (IDX_W + 1)'(MAX_FRAGMENTS);
    localparam logic [COUNT_W:0] COUNT_LIMIT = (COUNT_W + 1)'(MAX_FRAGMENTS);

    typedef enum logic [OP_W-1:0] {
        OP_START    = 2'd0,
        OP_FRAGMENT = 2'd1,
        OP_FREE     = 2'd2,
        OP_RESERVED = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_ACCEPTED  = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_UNKNOWN   = 3'd3,
        ST_RANGE     = 3'd4
    } status_t;

    typedef struct packed {
        logic [TOTAL_W-1:0]       total;
        logic [COUNT_W-1:0]       count;
        logic [MAX_FRAGMENTS-1:0] rx_map;
    } entry_t;

    typedef struct packed {
        op_t                op;
        logic [ID_W-1:0]    id;
        logic [IDX_W-1:0]   idx;
        logic [TOTAL_W-1:0] total;
        logic               empty;
    } stage_t;

endpackage

@@ src/frt_if.sv @@
// item and result channel interfaces
interface frt_item_if;
    import frt_pkg::*;

    logic                 valid;
    logic                 ready;
    op_t                  op;
    logic [ID_W-1:0]      transfer_id;
    logic [IDX_W-1:0]     fragment_index;
    logic [TOTAL_W-1:0]   total_fragments;
    logic [LEN_W-1:0]     payload_length;

    modport source (
        output valid, op, transfer_id, fragment_index, total_fragments, payload_length,
        input  ready
    );
    modport sink (
        input  valid, op, transfer_id, fragment_index, total_fragments, payload_length,
        output ready
    );
endinterface

interface frt_result_if;
    import frt_pkg::*;

    logic                 valid;
    logic                 ready;
    status_t              status;
    logic                 complete;
    logic [COUNT_W-1:0]   received_count;

    modport source (
        output valid, status, complete, received_count,
        input  ready
    );
    modport sink (
        input  valid, status, complete, received_count,
        output ready
    );
endinterface

@@ src/frt_entry_ram.sv @@
// entry table memory, one write and one registered read port
module frt_entry_ram (
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [frt_pkg::ADDR_W-1:0] wr_addr,
    input  frt_pkg::entry_t        wr_data,
    input  logic                   rd_en,
    input  logic [frt_pkg::ADDR_W-1:0] rd_addr,
    output frt_pkg::entry_t        rd_data
);
    import frt_pkg::*;

    entry_t mem [NUM_TRANSFER_IDS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/fragment_reassembly_tracker.sv @@
// fragment reassembly tracker top level
// result: an accepted item passes through the s1 register and then the result register
// throughput: one item per cycle; entry read-modify-write with forwarding of the last write
// stalls only when the result register is full and not taken
// reset: asynchronous, clears all entry valid bits and pipeline valids at once, no sweep
module fragment_reassembly_tracker (
    input  logic         clk,
    input  logic         rst_n,
    frt_item_if.sink     item,
    frt_result_if.source result
);
    import frt_pkg::*;

    logic                        adv;
    logic                        accept;
    logic                        s1_valid_reg;
    stage_t                      s1_reg;
    logic [NUM_TRANSFER_IDS-1:0] valid_reg;
    logic                        fwd_valid_reg;
    logic [ADDR_W-1:0]           fwd_addr_reg;
    entry_t                      fwd_data_reg;
    entry_t                      rd_data;
    entry_t                      cur;
    logic [ADDR_W-1:0]           addr;
    logic                        id_ok;
    logic                        entry_live;
    logic                        idx_ok;
    logic                        dup;
    logic                        commit;

    logic                        wr_req_next;
    entry_t                      wr_data_next;
    logic                        set_valid_next;
    logic                        clr_valid_next;
    status_t                     status_next;
    logic                        complete_next;
    logic [COUNT_W-1:0]          count_next;
    logic [COUNT_W-1:0]          count_inc;

    logic                        out_valid_reg;
    status_t                     out_status_reg;
    logic                        out_complete_reg;
    logic [COUNT_W-1:0]          out_count_reg;

    assign adv    = !out_valid_reg || result.ready;
    assign accept = item.valid && adv;
    assign commit = s1_valid_reg && adv;
    assign item.ready = adv;

    frt_entry_ram u_ram (
        .clk     (clk),
        .wr_en   (commit && wr_req_next),
        .wr_addr (addr),
        .wr_data (wr_data_next),
        .rd_en   (accept),
        .rd_addr (item.transfer_id[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    assign addr       = s1_reg.id[ADDR_W-1:0];
    assign id_ok      = {1'b0, s1_reg.id} < ID_LIMIT;
    assign entry_live = id_ok && valid_reg[addr];
    assign idx_ok     = {1'b0, s1_reg.idx} < IDX_LIMIT;
    assign cur        = (fwd_valid_reg && (fwd_addr_reg == addr)) ? fwd_data_reg : rd_data;
    assign dup        = cur.rx_map[s1_reg.idx[BIT_W-1:0]];
    assign count_inc  = cur.count + COUNT_W'(1);

    always_comb
    begin
        wr_req_next    = 1'b0;
        wr_data_next   = cur;
        set_valid_next = 1'b0;
        clr_valid_next = 1'b0;
        status_next    = ST_UNKNOWN;
        complete_next  = 1'b0;
        count_next     = '0;
        case (s1_reg.op)
            OP_START:
            begin
                if (s1_reg.empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (id_ok)
                begin
                    wr_req_next         = 1'b1;
                    set_valid_next      = 1'b1;
                    wr_data_next.total  = s1_reg.total;
                    wr_data_next.count  = COUNT_W'(1);
                    wr_data_next.rx_map = MAX_FRAGMENTS'(1);
                    status_next         = ST_ACCEPTED;
                    count_next          = COUNT_W'(1);
                    complete_next       = (s1_reg.total <= TOTAL_W'(1));
                end
            end
            OP_FRAGMENT:
            begin
                if (s1_reg.empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (entry_live)
                begin
                    if (!idx_ok || dup)
                    begin
                        status_next   = idx_ok ? ST_DUPLICATE : ST_RANGE;
                        count_next    = cur.count;
                        complete_next = ({1'b0, cur.count} >= cur.total);
                    end
                    else
                    begin
                        wr_req_next = 1'b1;
                        wr_data_next.rx_map[s1_reg.idx[BIT_W-1:0]] = 1'b1;
                        wr_data_next.count = count_inc;
                        status_next   = ST_ACCEPTED;
                        count_next    = count_inc;
                        complete_next = ({1'b0, count_inc} >= cur.total);
                    end
                end
            end
            OP_FREE:
            begin
                if (entry_live)
                begin
                    clr_valid_next = 1'b1;
                    status_next    = ST_ACCEPTED;
                end
            end
            default:
            begin
                status_next = ST_UNKNOWN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg  <= item.valid;
                out_valid_reg <= s1_valid_reg;
            end
            if (commit && set_valid_next)
            begin
                valid_reg[addr] <= 1'b1;
            end
            if (commit && clr_valid_next)
            begin
                valid_reg[addr] <= 1'b0;
            end
            if (commit && wr_req_next)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg.op    <= item.op;
            s1_reg.id    <= item.transfer_id;
            s1_reg.idx   <= item.fragment_index;
            s1_reg.total <= item.total_fragments;
            s1_reg.empty <= (item.payload_length == '0);
        end
        if (commit)
        begin
            out_status_reg   <= status_next;
            out_complete_reg <= complete_next;
            out_count_reg    <= count_next;
        end
        if (commit && wr_req_next)
        begin
            fwd_addr_reg <= addr;
            fwd_data_reg <= wr_data_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.status         = out_status_reg;
    assign result.complete       = out_complete_reg;
    assign result.received_count = out_count_reg;

endmodule

@@ src/frt_checker.sv @@
// port-level assertions for the fragment reassembly tracker and their bind
module frt_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        item_valid,
    input logic                        item_ready,
    input logic                        result_valid,
    input logic                        result_ready,
    input frt_pkg::status_t            result_status,
    input logic                        result_complete,
    input logic [frt_pkg::COUNT_W-1:0] result_count
);
    import frt_pkg::*;

    // a pending result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_status)
            && $stable(result_count) && $stable(result_complete))
        else $error("result dropped or changed while stalled");

    // a new result always follows an accepted item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && item_ready, 2))
        else $error("result without an accepted item");

    // results without an entry report nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_status == ST_EMPTY || result_status == ST_UNKNOWN)
            |-> !result_complete && (result_count == '0))
        else $error("empty or unknown result carries entry data");

    // received counts stay within the fragment limit; duplicate and range reports come from an open entry
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ({1'b0, result_count} <= COUNT_LIMIT)
            && ((result_status != ST_DUPLICATE && result_status != ST_RANGE)
                || (result_count != '0)))
        else $error("received count out of range");

endmodule

bind fragment_reassembly_tracker frt_checker u_frt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item.valid),
    .item_ready      (item.ready),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .result_status   (result.status),
    .result_complete (result.complete),
    .result_count    (result.received_count)
);

@@ test/fragment_reassembly_tracker_tb.sv @@
// self-checking testbench of the fragment reassembly tracker with a table predictor
`timescale 1ns / 100ps

module fragment_reassembly_tracker_tb;
    import frt_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int ITEM_TARGET    = 600;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct {
        status_t            status;
        logic               complete;
        logic [COUNT_W-1:0] received_count;
    } tracker_result_t;

    logic clk = 1'b0;
    logic rst_n;

    frt_item_if   item_if();
    frt_result_if result_if();

    fragment_reassembly_tracker u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if)
    );

    bit                       shadow_valid [NUM_TRANSFER_IDS];
    logic [TOTAL_W-1:0]       shadow_total [NUM_TRANSFER_IDS];
    logic [COUNT_W-1:0]       shadow_count [NUM_TRANSFER_IDS];
    logic [MAX_FRAGMENTS-1:0] shadow_map   [NUM_TRANSFER_IDS];

    tracker_result_t expected_results[$];
    tracker_result_t oldest_result;

    int error_count = 0;
    int items_sent  = 0;
    int idle_cycles = 0;
    int hold_left   = 0;
    bit hold_req    = 1'b0;
    bit no_idle     = 1'b0;

    always #10 clk = ~clk;

    function automatic tracker_result_t entry_result(status_t status, int id);
        tracker_result_t res;
        res.status         = status;
        res.received_count = shadow_count[id];
        res.complete       = (int'(shadow_count[id]) >= int'(shadow_total[id]));
        return res;
    endfunction

    function automatic void predict_tracker(op_t op, logic [ID_W-1:0] id,
                                            logic [IDX_W-1:0] idx,
                                            logic [TOTAL_W-1:0] total,
                                            logic [LEN_W-1:0] len);
        tracker_result_t res;
        int              slot;
        bit              id_ok;
        slot  = int'(id);
        id_ok = slot < NUM_TRANSFER_IDS;
        res.status         = ST_UNKNOWN;
        res.complete       = 1'b0;
        res.received_count = '0;
        case (op)
            OP_START:
            begin
                if (len == '0)
                    res.status = ST_EMPTY;
                else if (id_ok)
                begin
                    shadow_valid[slot] = 1'b1;
                    shadow_total[slot] = total;
                    shadow_count[slot] = COUNT_W'(1);
                    shadow_map[slot]   = MAX_FRAGMENTS'(1);
                    res = entry_result(ST_ACCEPTED, slot);
                end
            end
            OP_FRAGMENT:
            begin
                if (len == '0)
                    res.status = ST_EMPTY;
                else if (id_ok && shadow_valid[slot])
                begin
                    if (int'(idx) >= MAX_FRAGMENTS)
                        res = entry_result(ST_RANGE, slot);
                    else if (shadow_map[slot][idx[BIT_W-1:0]])
                        res = entry_result(ST_DUPLICATE, slot);
                    else
                    begin
                        shadow_map[slot][idx[BIT_W-1:0]] = 1'b1;
                        shadow_count[slot] = shadow_count[slot] + COUNT_W'(1);
                        res = entry_result(ST_ACCEPTED, slot);
                    end
                end
            end
            OP_FREE:
            begin
                if (id_ok && shadow_valid[slot])
                begin
                    shadow_valid[slot] = 1'b0;
                    res.status = ST_ACCEPTED;
                end
            end
            default:
            begin
                res.status = ST_UNKNOWN;
            end
        endcase
        expected_results.insert(expected_results.size(), res);
    endfunction

    // entered and left at a falling edge
    task automatic send_item(op_t op, logic [ID_W-1:0] id, logic [IDX_W-1:0] idx,
                             logic [TOTAL_W-1:0] total, logic [LEN_W-1:0] len);
        int gaps;
        gaps = 0;
        if (!no_idle)
            while ($urandom_range(99) < 30)
                gaps++;
        if (gaps > 0)
        begin
            item_if.valid <= 1'b0;
            repeat (gaps) @(negedge clk);
        end
        item_if.valid           <= 1'b1;
        item_if.op              <= op;
        item_if.transfer_id     <= id;
        item_if.fragment_index  <= idx;
        item_if.total_fragments <= total;
        item_if.payload_length  <= len;
        do
            @(posedge clk);
        while (!item_if.ready);
        predict_tracker(op, id, idx, total, len);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_noise();
        logic [LEN_W-1:0] len;
        len = ($urandom_range(9) == 0) ? '0 : LEN_W'($urandom);
        send_item(op_t'($urandom_range(3)), ID_W'($urandom), IDX_W'($urandom),
                  TOTAL_W'($urandom), len);
    endtask

    task automatic send_transfer(logic [ID_W-1:0] id, int total);
        int idx_list[MAX_FRAGMENTS];
        int span;
        int pick;
        int tmp;
        span = (total > MAX_FRAGMENTS) ? MAX_FRAGMENTS : total;
        for (int i = 0; i < MAX_FRAGMENTS; i++)
            idx_list[i] = i;
        for (int i = span - 1; i > 1; i--)
        begin
            pick = $urandom_range(i, 1);
            tmp = idx_list[i];
            idx_list[i] = idx_list[pick];
            idx_list[pick] = tmp;
        end
        send_item(OP_START, id, IDX_W'($urandom), TOTAL_W'(total),
                  LEN_W'($urandom_range(65535, 1)));
        for (int i = 1; i < span; i++)
        begin
            if ($urandom_range(99) < 5)
                send_noise();
            if ($urandom_range(99) < 4)
                send_item(OP_FRAGMENT, id, IDX_W'($urandom), '0, '0);
            if ($urandom_range(99) < 4)
                send_item(OP_FRAGMENT, id, IDX_W'(idx_list[$urandom_range(i - 1)]),
                          TOTAL_W'($urandom), LEN_W'($urandom_range(65535, 1)));
            if ($urandom_range(99) < 3)
                send_item(OP_FRAGMENT, id, IDX_W'($urandom_range(255, MAX_FRAGMENTS)),
                          TOTAL_W'($urandom), LEN_W'($urandom_range(65535, 1)));
            send_item(OP_FRAGMENT, id, IDX_W'(idx_list[i]), TOTAL_W'($urandom),
                      LEN_W'($urandom_range(65535, 1)));
        end
        if ($urandom_range(99) < 80)
        begin
            send_item(OP_FREE, id, IDX_W'($urandom), TOTAL_W'($urandom), LEN_W'($urandom));
            if ($urandom_range(99) < 10)
                send_item(OP_FRAGMENT, id, IDX_W'($urandom_range(MAX_FRAGMENTS - 1)),
                          TOTAL_W'($urandom), LEN_W'($urandom_range(65535, 1)));
        end
    endtask

    task automatic test_directed_cases();
        send_item(OP_FRAGMENT, 8'd5, 8'd1, 8'd0, 16'd100);
        send_item(OP_FREE, 8'd5, 8'd0, 8'd0, 16'd0);
        send_item(OP_RESERVED, 8'd5, 8'd0, 8'd0, 16'd7);
        send_item(OP_START, 8'd5, 8'd0, 8'd4, 16'd0);
        send_item(OP_START, 8'd0, 8'd0, 8'd0, 16'hFFFF);
        send_item(OP_START, 8'd255, 8'd255, 8'd255, 16'd1);
        send_item(OP_FRAGMENT, 8'd255, 8'd63, 8'd0, 16'hFFFF);
        send_item(OP_FRAGMENT, 8'd255, 8'd64, 8'd0, 16'd1);
        send_item(OP_FRAGMENT, 8'd255, 8'd255, 8'd255, 16'd1);
        send_item(OP_FRAGMENT, 8'd255, 8'd0, 8'd0, 16'd1);
        send_item(OP_FRAGMENT, 8'd255, 8'd63, 8'd0, 16'd2);
        send_item(OP_FRAGMENT, 8'd255, 8'd5, 8'd0, 16'd0);
        send_item(OP_START, 8'd1, 8'd0, 8'd1, 16'd10);
        send_item(OP_START, 8'd2, 8'd0, 8'd2, 16'd10);
        send_item(OP_FRAGMENT, 8'd2, 8'd1, 8'd0, 16'd10);
        send_item(OP_FRAGMENT, 8'd2, 8'd1, 8'd0, 16'd10);
        send_item(OP_START, 8'd2, 8'd0, 8'd3, 16'd10);
        send_item(OP_FREE, 8'd2, 8'd0, 8'd0, 16'd0);
        send_item(OP_FREE, 8'd2, 8'd0, 8'd0, 16'd0);
        send_item(OP_FRAGMENT, 8'd2, 8'd1, 8'd0, 16'd10);
        send_item(OP_FREE, 8'd0, 8'd255, 8'd255, 16'hFFFF);
        send_item(OP_FREE, 8'd255, 8'd0, 8'd0, 16'd0);
        send_item(OP_FREE, 8'd1, 8'd0, 8'd0, 16'd0);
        send_item(OP_RESERVED, 8'd255, 8'd255, 8'd255, 16'hFFFF);
    endtask

    task automatic test_backpressure();
        no_idle  = 1'b1;
        hold_req = 1'b1;
        repeat (6)
            send_transfer(ID_W'($urandom), $urandom_range(16, 8));
        no_idle = 1'b0;
    endtask

    task automatic test_random_transfers();
        int r;
        int total;
        while (items_sent < ITEM_TARGET)
        begin
            r = $urandom_range(99);
            if (r < 70)
                total = $urandom_range(8, 1);
            else if (r < 85)
                total = $urandom_range(MAX_FRAGMENTS, 9);
            else if (r < 88)
                total = MAX_FRAGMENTS;
            else if (r < 94)
                total = 0;
            else
                total = $urandom_range(255, MAX_FRAGMENTS + 1);
            send_transfer(ID_W'($urandom), total);
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_if.ready <= 1'b0;
        end
        else if (no_idle)
            result_if.ready <= 1'b1;
        else
            result_if.ready <= ($urandom_range(99) >= 30);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result status %0d complete %0d count %0d", $time,
                         result_if.status, result_if.complete, result_if.received_count);
                error_count++;
            end
            else
            begin
                oldest_result = expected_results.pop_front();
                if (result_if.status !== oldest_result.status)
                begin
                    $display("%0t: status expected %0d got %0d", $time,
                             oldest_result.status, result_if.status);
                    error_count++;
                end
                if (result_if.complete !== oldest_result.complete)
                begin
                    $display("%0t: complete expected %0d got %0d", $time,
                             oldest_result.complete, result_if.complete);
                    error_count++;
                end
                if (result_if.received_count !== oldest_result.received_count)
                begin
                    $display("%0t: received_count expected %0d got %0d", $time,
                             oldest_result.received_count, result_if.received_count);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("fragment_reassembly_tracker_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        rst_n                   = 1'b0;
        item_if.valid           = 1'b0;
        item_if.op              = OP_START;
        item_if.transfer_id     = '0;
        item_if.fragment_index  = '0;
        item_if.total_fragments = '0;
        item_if.payload_length  = '0;
        result_if.ready         = 1'b0;
        for (int i = 0; i < NUM_TRANSFER_IDS; i++)
            shadow_valid[i] = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_backpressure();
        test_random_transfers();
        item_if.valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("fragment_reassembly_tracker_tb OK");
        else
            $display("fragment_reassembly_tracker_tb NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
src/frt_pkg.sv
src/frt_if.sv
src/frt_entry_ram.sv
src/fragment_reassembly_tracker.sv
src/frt_checker.sv
test/fragment_reassembly_tracker_tb.sv
